// ===== sv/preemptive_priority_scheduler_unit_macros.svh =====
// assertion macros used by the scheduler top level
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define PPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pps_pkg.sv =====
// types and constants shared by the scheduler modules
package pps_pkg;

    localparam int TIME_W  = 16;
    localparam int SUM_W   = 20;
    localparam int COUNT_W = 5;
    localparam int PRIO_W  = 8;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // input word opcodes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // one process table entry as held in the memory
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] priority_level;
        logic [TIME_W-1:0] remaining;
    } entry_t;

endpackage

// ===== sv/pps_ram.sv =====
// generic simple dual port ram with registered read
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/pps_pick.sv =====
// running best-candidate selector fed one table entry per cycle
module pps_pick #(
    parameter int SLOT_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          cand_en,
    input  logic [SLOT_W-1:0]             cand_idx,
    input  pps_pkg::entry_t               cand_entry,
    input  logic [pps_pkg::TIME_W-1:0]    cur_time,
    output logic                          found,
    output logic [SLOT_W-1:0]             best_idx,
    output pps_pkg::entry_t               best_entry
);

    logic            found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    pps_pkg::entry_t best_entry_reg;
    logic            ready_c;
    logic            better_c;

    // ready: arrived and work left; better: lower priority number, then earlier arrival
    always_comb
    begin
        ready_c  = (cand_entry.arrival <= cur_time) && (cand_entry.remaining != '0);
        better_c = !found_reg
                || (cand_entry.priority_level < best_entry_reg.priority_level)
                || ((cand_entry.priority_level == best_entry_reg.priority_level)
                    && (cand_entry.arrival < best_entry_reg.arrival));
    end

    // found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (cand_en && ready_c)
        begin
            found_reg <= 1'b1;
        end
    end

    // best entry payload, lower slot wins ties by scan order
    always_ff @(posedge clk)
    begin
        if (!clear && cand_en && ready_c && better_c)
        begin
            best_idx_reg   <= cand_idx;
            best_entry_reg <= cand_entry;
        end
    end

    assign found      = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;

endmodule

// ===== sv/preemptive_priority_scheduler_unit.sv =====
// Preemptive priority scheduler top level.
// Input channel (in_valid/in_ready) carries words: mode load writes one process
// slot (arrival, burst, priority) into the table memory and gives
// no result; mode tick scans slots 0 .. min(process_count, MAX_PROCESSES)-1,
// runs the ready slot with the lowest priority number for one tick and gives
// one result word on the output channel (out_valid/out_ready).
// process_count is written through cfg_we/cfg_wdata; write it only while the
// block is idle, as the block does not enforce this. A tick passes through
// scan, where the single read port of the table memory reads one slot per
// cycle, then drain, where the last read data enters the selector, then
// commit, which registers the result word; the next word is taken once the
// block is back in idle. With no slots to scan a tick goes straight to commit.
// Reset clears time, sums, completed count, the last running slot and the
// per-slot valid bits, so every slot starts with no work; the table memory
// itself is not cleared. When the receiver stalls, the result word holds in
// the output register; loads still go in, and a following tick completes its
// scan and waits in commit until the output register is free.
`include "preemptive_priority_scheduler_unit_macros.svh"

module preemptive_priority_scheduler_unit #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [3:0]  slot,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_length,
    input  logic [7:0]  priority_level,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  running_slot,
    output logic        idle,
    output logic        switched,
    output logic        finished,
    output logic [15:0] finish_time,
    output logic [15:0] turnaround,
    output logic [15:0] waiting,
    output logic [19:0] total_turnaround,
    output logic [19:0] total_waiting,
    output logic        all_done
);

    localparam int SLOT_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int ENTRY_W = $bits(pps_pkg::entry_t);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_COMMIT} state_t;

    state_t                          state_reg;
    logic [pps_pkg::COUNT_W-1:0]     process_count_reg;
    logic [MAX_PROCESSES-1:0]        entry_valid_reg;
    logic [SLOT_W-1:0]               scan_idx_reg;
    logic [SLOT_W-1:0]               rd_idx_reg;
    logic                            rd_pend_reg;
    logic [pps_pkg::TIME_W-1:0]      time_reg;
    logic                            last_valid_reg;
    logic [SLOT_W-1:0]               last_idx_reg;
    logic [pps_pkg::COUNT_W-1:0]     completed_reg;
    logic [pps_pkg::SUM_W-1:0]       tat_sum_reg;
    logic [pps_pkg::SUM_W-1:0]       wt_sum_reg;

    logic                            out_valid_reg;
    logic [3:0]                      running_slot_reg;
    logic                            idle_reg;
    logic                            switched_reg;
    logic                            finished_reg;
    logic [pps_pkg::TIME_W-1:0]      finish_time_reg;
    logic [pps_pkg::TIME_W-1:0]      turnaround_reg;
    logic [pps_pkg::TIME_W-1:0]      waiting_reg;
    logic [pps_pkg::SUM_W-1:0]       total_tat_reg;
    logic [pps_pkg::SUM_W-1:0]       total_wt_reg;
    logic                            all_done_reg;

    logic [CNT_W-1:0]                limit_c;
    logic                            in_fire;
    logic                            load_ok;
    logic                            commit_go;
    logic                            scan_last;

    logic                            ram_we;
    logic [SLOT_W-1:0]               ram_waddr;
    pps_pkg::entry_t                 ram_wdata;
    logic                            ram_re;
    logic [ENTRY_W-1:0]              ram_rdata;
    pps_pkg::entry_t                 rd_entry;

    logic                            pick_clear;
    logic                            pick_en;
    logic                            pick_found;
    logic [SLOT_W-1:0]               pick_idx;
    pps_pkg::entry_t                 pick_entry;

    logic [pps_pkg::TIME_W-1:0]      time_next;
    logic [pps_pkg::TIME_W-1:0]      rem_dec;
    logic                            fin_c;
    logic [pps_pkg::TIME_W-1:0]      tat_c;
    logic [pps_pkg::TIME_W-1:0]      wt_c;
    logic [pps_pkg::SUM_W:0]         tat_sum_wide;
    logic [pps_pkg::SUM_W:0]         wt_sum_wide;
    logic [pps_pkg::SUM_W-1:0]       tat_sum_next;
    logic [pps_pkg::SUM_W-1:0]       wt_sum_next;
    logic [pps_pkg::COUNT_W-1:0]     completed_next;
    logic                            switched_c;

    // handshake and scan limit
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        in_fire   = in_valid && in_ready;
        load_ok   = (int'(slot) < MAX_PROCESSES);
        limit_c   = (int'(process_count_reg) > MAX_PROCESSES)
                  ? CNT_W'(MAX_PROCESSES) : CNT_W'(process_count_reg);
        scan_last = (CNT_W'(scan_idx_reg) == (limit_c - CNT_W'(1)));
        commit_go = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);
    end

    // table memory port control: loads and commit share the write port
    always_comb
    begin
        ram_re    = (state_reg == ST_SCAN);
        ram_we    = 1'b0;
        ram_waddr = SLOT_W'(slot);
        ram_wdata = '{arrival: arrival_time, burst: burst_length,
                      priority_level: priority_level, remaining: burst_length};
        if (commit_go)
        begin
            ram_we    = pick_found;
            ram_waddr = pick_idx;
            ram_wdata = pick_entry;
            ram_wdata.remaining = rem_dec;
        end
        else if (in_fire && (mode == pps_pkg::MODE_LOAD) && load_ok)
        begin
            ram_we = 1'b1;
        end
    end

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCESSES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // read data enters the selector; slots never loaded hold no work
    always_comb
    begin
        rd_entry   = pps_pkg::entry_t'(ram_rdata);
        pick_en    = rd_pend_reg && entry_valid_reg[rd_idx_reg];
        pick_clear = in_fire && (mode == pps_pkg::MODE_TICK);
    end

    pps_pick #(
        .SLOT_W (SLOT_W)
    ) u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (pick_clear),
        .cand_en    (pick_en),
        .cand_idx   (rd_idx_reg),
        .cand_entry (rd_entry),
        .cur_time   (time_reg),
        .found      (pick_found),
        .best_idx   (pick_idx),
        .best_entry (pick_entry)
    );

    // tick bookkeeping with saturation
    always_comb
    begin
        time_next    = (time_reg == pps_pkg::TIME_MAX) ? time_reg : time_reg + 1'b1;
        rem_dec      = pick_entry.remaining - 1'b1;
        fin_c        = pick_found && (rem_dec == '0);
        tat_c        = time_next - pick_entry.arrival;
        wt_c         = (tat_c >= pick_entry.burst) ? tat_c - pick_entry.burst : '0;
        tat_sum_wide = {1'b0, tat_sum_reg} + (pps_pkg::SUM_W+1)'(tat_c);
        wt_sum_wide  = {1'b0, wt_sum_reg} + (pps_pkg::SUM_W+1)'(wt_c);
        tat_sum_next = tat_sum_reg;
        wt_sum_next  = wt_sum_reg;
        completed_next = completed_reg;
        if (fin_c)
        begin
            tat_sum_next = (tat_sum_wide > (pps_pkg::SUM_W+1)'(pps_pkg::SUM_MAX))
                         ? pps_pkg::SUM_MAX : tat_sum_wide[pps_pkg::SUM_W-1:0];
            wt_sum_next  = (wt_sum_wide > (pps_pkg::SUM_W+1)'(pps_pkg::SUM_MAX))
                         ? pps_pkg::SUM_MAX : wt_sum_wide[pps_pkg::SUM_W-1:0];
            completed_next = (completed_reg == pps_pkg::COUNT_MAX)
                           ? completed_reg : completed_reg + 1'b1;
        end
        if (pick_found)
        begin
            switched_c = !last_valid_reg || (last_idx_reg != pick_idx);
        end
        else
        begin
            switched_c = last_valid_reg;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            process_count_reg <= cfg_wdata;
        end
    end

    // sequencer, scheduler state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_valid_reg <= '0;
            scan_idx_reg    <= '0;
            rd_idx_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            time_reg        <= '0;
            last_valid_reg  <= 1'b0;
            last_idx_reg    <= '0;
            completed_reg   <= '0;
            tat_sum_reg     <= '0;
            wt_sum_reg      <= '0;
            out_valid_reg   <= 1'b0;
            running_slot_reg <= '0;
            idle_reg         <= 1'b0;
            switched_reg     <= 1'b0;
            finished_reg     <= 1'b0;
            finish_time_reg  <= '0;
            turnaround_reg   <= '0;
            waiting_reg      <= '0;
            total_tat_reg    <= '0;
            total_wt_reg     <= '0;
            all_done_reg     <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == ST_SCAN);
            rd_idx_reg  <= scan_idx_reg;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (mode == pps_pkg::MODE_LOAD)
                        begin
                            if (load_ok)
                            begin
                                entry_valid_reg[SLOT_W'(slot)] <= 1'b1;
                            end
                        end
                        else if (limit_c == '0)
                        begin
                            state_reg <= ST_COMMIT;
                        end
                        else
                        begin
                            scan_idx_reg <= '0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (commit_go)
                    begin
                        state_reg      <= ST_IDLE;
                        time_reg       <= time_next;
                        last_valid_reg <= pick_found;
                        last_idx_reg   <= pick_found ? pick_idx : '0;
                        completed_reg  <= completed_next;
                        tat_sum_reg    <= tat_sum_next;
                        wt_sum_reg     <= wt_sum_next;
                        out_valid_reg  <= 1'b1;
                        running_slot_reg <= pick_found ? 4'(pick_idx) : '0;
                        idle_reg         <= !pick_found;
                        switched_reg     <= switched_c;
                        finished_reg     <= fin_c;
                        finish_time_reg  <= fin_c ? time_next : '0;
                        turnaround_reg   <= fin_c ? tat_c : '0;
                        waiting_reg      <= fin_c ? wt_c : '0;
                        total_tat_reg    <= tat_sum_next;
                        total_wt_reg     <= wt_sum_next;
                        all_done_reg     <= (completed_next == process_count_reg);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign out_valid        = out_valid_reg;
    assign running_slot     = running_slot_reg;
    assign idle             = idle_reg;
    assign switched         = switched_reg;
    assign finished         = finished_reg;
    assign finish_time      = finish_time_reg;
    assign turnaround       = turnaround_reg;
    assign waiting          = waiting_reg;
    assign total_turnaround = total_tat_reg;
    assign total_waiting    = total_wt_reg;
    assign all_done         = all_done_reg;

    // checks
    `PPS_ASSERT_IMPL(a_finish_not_idle, out_valid_reg && finished_reg, !idle_reg, "idle finish")
    `PPS_ASSERT_NEXT(a_time_only_on_commit, !commit_go, $stable(time_reg), "time moved")
    `PPS_ASSERT_NEXT(a_count_monotonic, 1'b1, completed_reg >= $past(completed_reg), "count fell")
    `PPS_ASSERT_IMPL(a_no_write_in_scan, state_reg == ST_SCAN || state_reg == ST_DRAIN, !ram_we, "scan write")

endmodule
